// ----- rtl/pmbp_pkg.sv -----
// Package of shared types and constants for the palette match bitplane packer.
`timescale 1ns / 1ps

package pmbp_pkg;

    // Fixed field widths
    localparam int unsigned RGB_W      = 24;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned ENTRY_W    = 5;
    localparam int unsigned PLANE_W    = 3;
    localparam int unsigned WORD_BITS  = 16;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    // Colour index as seen by the plane select: one bit per plane code
    localparam int unsigned PLANE_SEL_W = 8;

    typedef logic [RGB_W-1:0]     t_rgb;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_PALETTE_COUNT = 2'd0;
    localparam t_cfg_idx CFG_MASK_COLOR    = 2'd1;
    localparam t_cfg_idx CFG_MASK_ENABLE   = 2'd2;

    // Item operation codes
    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_PIXEL         = 1'b1;

    // Last position of a sixteen pixel group
    localparam t_pos POS_LAST = 4'hF;

    // Reset value of the palette count register
    localparam t_count PALETTE_COUNT_RESET = 6'd32;

endpackage

// ----- rtl/palette_match_bitplane_packer_unit.sv -----
// Top level of the palette match bitplane packer: palette search and plane packing.
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_stall) carries one item per transfer: with
// i_op low it loads palette entry i_entry_index with i_red/i_green/i_blue,
// with i_op high it is a pixel whose colour index bit i_plane is packed.
// Every pixel is compared against all palette entries below palette_count in
// parallel; the highest matching entry wins, an unmatched mask colour packs
// index 0, any other unmatched pixel packs 0 and flags a colour error.
// After every sixteenth pixel one result (o_plane_word, o_mask_word,
// o_color_error) is offered on the output channel (o_out_valid / i_out_stall).
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
// palette count, mask colour and mask enable; write them only while idle.
// An item is matched and packed while it sits in the input register; a
// result is loaded into the result register as its last pixel leaves the
// input register. One item is taken every cycle, bounded only by the compare
// array; the input stalls only when a group-closing pixel waits behind an
// unread result on a stalled output.
// Reset clears the group state, the pending items and the configuration;
// palette contents are kept undefined until written.

module palette_match_bitplane_packer_unit #(
    parameter int unsigned PALETTE_DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_op,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    input  logic [4:0]                i_entry_index,
    input  logic [2:0]                i_plane,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [15:0]               o_plane_word,
    output logic [15:0]               o_mask_word,
    output logic                      o_color_error,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  pmbp_pkg::t_cfg_idx        i_cfg_index,
    input  pmbp_pkg::t_rgb            i_cfg_data
);

    import pmbp_pkg::*;

    localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // Configuration registers
    t_count           r_pal_count;
    t_rgb             r_mask_color;
    logic             r_mask_en;

    // Input register
    logic             r_s1_vld, n_s1_vld;
    logic             r_op;
    t_rgb             r_rgb;
    logic [4:0]       r_entry;
    logic [2:0]       r_plane;

    // Palette entries, one comparator each
    t_rgb             r_pal [PALETTE_DEPTH];

    // Group state
    t_word            r_plane_shift, n_plane_shift;
    t_word            r_mask_shift,  n_mask_shift;
    t_pos             r_pos;
    logic             r_err, n_err;

    // Result register
    logic             r_out_vld, n_out_vld;
    t_word            r_out_plane;
    t_word            r_out_mask;
    logic             r_out_err;

    // Datapath
    logic [PALETTE_DEPTH-1:0] match;
    logic                     found;
    logic [IDX_W-1:0]         idx;
    logic [PLANE_SEL_W-1:0]   idx_ext;
    logic                     is_mask;
    logic                     emits;
    logic                     adv;
    logic                     in_xfer;

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_count  <= PALETTE_COUNT_RESET;
            r_mask_color <= '0;
            r_mask_en    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PALETTE_COUNT: r_pal_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_MASK_COLOR:    r_mask_color <= i_cfg_data;
                CFG_MASK_ENABLE:   r_mask_en    <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Advance the input stage unless a group result would overrun a held result
    assign emits      = (r_op == OP_PIXEL) && (r_pos == POS_LAST);
    assign adv        = r_s1_vld && (!emits || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign n_s1_vld   = in_xfer || (r_s1_vld && !adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= i_op;
            r_rgb   <= {i_red, i_green, i_blue};
            r_entry <= i_entry_index;
            r_plane <= i_plane;
        end
    end

    // Load palette entries; indexes past the depth decode to nothing
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            if (adv && (r_op == OP_PALETTE_WRITE) && (int'(r_entry) == i)) begin
                r_pal[i] <= r_rgb;
            end
        end
    end

    // Compare against every searched entry and keep the highest hit
    always_comb begin
        match = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            match[i] = (r_pal[i] == r_rgb) && (i < int'(r_pal_count));
        end
    end

    always_comb begin
        idx = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            if (match[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign found   = |match;
    assign idx_ext = PLANE_SEL_W'(idx);
    assign is_mask = r_mask_en && (r_rgb == r_mask_color);

    // Shift the plane and mask bits of this pixel into the group words
    assign n_plane_shift = {r_plane_shift[WORD_BITS-2:0], found & idx_ext[r_plane]};
    assign n_mask_shift  = {r_mask_shift[WORD_BITS-2:0], ~is_mask};
    assign n_err         = r_err | (~found & ~is_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_shift <= '0;
            r_mask_shift  <= '0;
            r_pos         <= '0;
            r_err         <= 1'b0;
        end else if (adv && (r_op == OP_PIXEL)) begin
            r_plane_shift <= n_plane_shift;
            r_mask_shift  <= n_mask_shift;
            r_pos         <= r_pos + 1'b1;
            r_err         <= emits ? 1'b0 : n_err;
        end
    end

    // Result register: load on group close, drop once transferred
    always_comb begin
        if (adv && emits) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emits) begin
            r_out_plane <= n_plane_shift;
            r_out_mask  <= n_mask_shift;
            r_out_err   <= n_err;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_plane_word  = r_out_plane;
    assign o_mask_word   = r_out_mask;
    assign o_color_error = r_out_err;

`ifndef NO_ASSERTIONS
    // Input stalls only behind a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_vld && i_out_stall && emits))
        else $error("input stall without a blocked result");

    // Closing a group restarts position and error and offers a result
    a_group_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emits) |=> (r_pos == '0) && !r_err && r_out_vld)
        else $error("group close did not restart the group");

    // Palette writes never create a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_op == OP_PALETTE_WRITE) && !r_out_vld) |=> !r_out_vld)
        else $error("palette write produced a result");

    // Each pixel moves the group position on by one
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_op == OP_PIXEL)) |=> (r_pos == POS_W'($past(r_pos) + 1'b1)))
        else $error("group position did not advance");
`endif

endmodule
